// ----- rtl/lge_pkg.sv -----
// lge_pkg: shared types and constants for the life grid engine
// command and response payloads, operation codes and the internal row-operation format
// no dependencies
`default_nettype none

package lge_pkg;

	// operation codes of the command mode field
	localparam logic [2:0] MODE_WRITE  = 3'd0;
	localparam logic [2:0] MODE_READ   = 3'd1;
	localparam logic [2:0] MODE_CLEAR  = 3'd2;
	localparam logic [2:0] MODE_BLOCK  = 3'd3;
	localparam logic [2:0] MODE_GLIDER = 3'd4;
	localparam logic [2:0] MODE_STEP   = 3'd5;

	// widest row index and row the engine supports
	localparam int ROW_IDX_W = 8;
	localparam int ROW_BITS  = 64;

	// depth of the queue between front and back
	localparam int QUEUE_DEPTH = 4;
	localparam int QUEUE_PTR_W = 2;

	typedef struct packed {
		logic [2:0]  mode;
		logic [5:0]  row;
		logic [5:0]  col;
		logic [1:0]  direction;
		logic [63:0] row_data;
	} cmd_t;

	typedef struct packed {
		logic [63:0] row_cells;
		logic [2:0]  done_mode;
	} rsp_t;

	// row operations the back part carries out
	typedef enum logic [2:0] {
		UOP_NOP   = 3'd0,
		UOP_WRITE = 3'd1,
		UOP_READ  = 3'd2,
		UOP_CLEAR = 3'd3,
		UOP_SET   = 3'd4,
		UOP_STEP  = 3'd5
	} uop_kind_t;

	typedef struct packed {
		uop_kind_t              kind;
		logic [ROW_IDX_W-1:0]   row;
		logic [ROW_BITS-1:0]    data;
		logic [2:0]             mode;
		logic                   last;
	} uop_t;

endpackage

`default_nettype wire

// ----- rtl/lge_front.sv -----
// lge_front: takes commands and breaks each one into row operations
// patterns become one or more row set operations with column masks
// depends on lge_pkg
`default_nettype none

module lge_front import lge_pkg::*; #(
	parameter int GRID_ROWS = 64,
	parameter int GRID_COLS = 64
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic start,
	input  wire cmd_t cmd,
	output logic      busy,
	output logic      push,
	output uop_t      uop,
	input  wire logic full
);

	localparam int RW = (GRID_ROWS > 1) ? $clog2(GRID_ROWS) : 1;

	cmd_t             cmd_q;
	logic             act_q;
	logic [1:0]       idx_q;

	logic [8:0]           row_x;
	logic [6:0]           col_x;
	logic                 row_ok;
	logic                 col_ok;
	logic [RW-1:0]        r_idx;
	logic [RW-1:0]        u_idx;
	logic [RW-1:0]        d_idx;
	logic [RW-1:0]        head_idx;
	logic [RW-1:0]        tail_idx;
	logic [GRID_COLS-1:0] m_c;
	logic [GRID_COLS-1:0] m_l;
	logic [GRID_COLS-1:0] m_g;
	logic [GRID_COLS-1:0] m_side;
	logic [1:0]           n_last;
	uop_t                 u0;
	uop_t                 u1;
	uop_t                 u2;

	function automatic uop_t mk(uop_kind_t k, logic [RW-1:0] r, logic [ROW_BITS-1:0] d,
			logic [2:0] m);
		uop_t u;
		u.kind = k;
		u.row  = ROW_IDX_W'(r);
		u.data = d;
		u.mode = m;
		u.last = 1'b0;
		return u;
	endfunction

	assign row_x  = {3'b000, cmd_q.row};
	assign col_x  = {1'b0, cmd_q.col};
	assign row_ok = row_x < 9'(GRID_ROWS);
	assign col_ok = col_x < 7'(GRID_COLS);
	assign r_idx  = row_x[RW-1:0];
	assign u_idx  = (r_idx == '0) ? RW'(GRID_ROWS - 1) : r_idx - RW'(1);
	assign d_idx  = (r_idx == RW'(GRID_ROWS - 1)) ? '0 : r_idx + RW'(1);
	assign head_idx = cmd_q.direction[1] ? d_idx : u_idx;
	assign tail_idx = cmd_q.direction[1] ? u_idx : d_idx;

	// column masks, wrapping within the grid width
	assign m_c    = {{(GRID_COLS-1){1'b0}}, 1'b1} << cmd_q.col;
	assign m_l    = {m_c[0], m_c[GRID_COLS-1:1]};
	assign m_g    = {m_c[GRID_COLS-2:0], m_c[GRID_COLS-1]};
	assign m_side = cmd_q.direction[0] ? m_g : m_l;

	always_comb begin
		u0     = mk(UOP_NOP, '0, '0, cmd_q.mode);
		u1     = u0;
		u2     = u0;
		n_last = 2'd0;
		case (cmd_q.mode)
			MODE_WRITE: begin
				if (row_ok)
					u0 = mk(UOP_WRITE, r_idx, cmd_q.row_data, cmd_q.mode);
			end
			MODE_READ: begin
				if (row_ok)
					u0 = mk(UOP_READ, r_idx, '0, cmd_q.mode);
			end
			MODE_CLEAR: u0 = mk(UOP_CLEAR, '0, '0, cmd_q.mode);
			MODE_STEP:  u0 = mk(UOP_STEP, '0, '0, cmd_q.mode);
			MODE_BLOCK: begin
				if (row_ok && col_ok) begin
					u0 = mk(UOP_SET, r_idx, ROW_BITS'(m_c | m_g), cmd_q.mode);
					u1 = mk(UOP_SET, d_idx, ROW_BITS'(m_c | m_g), cmd_q.mode);
					n_last = 2'd1;
				end
			end
			MODE_GLIDER: begin
				if (row_ok && col_ok) begin
					u0 = mk(UOP_SET, head_idx, ROW_BITS'(m_l | m_c | m_g), cmd_q.mode);
					u1 = mk(UOP_SET, r_idx, ROW_BITS'(m_side), cmd_q.mode);
					u2 = mk(UOP_SET, tail_idx, ROW_BITS'(m_c), cmd_q.mode);
					n_last = 2'd2;
				end
			end
			default: ;
		endcase
	end

	always_comb begin
		case (idx_q)
			2'd0:    uop = u0;
			2'd1:    uop = u1;
			default: uop = u2;
		endcase
		uop.last = (idx_q == n_last);
	end

	assign busy = act_q;
	assign push = act_q && !full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_q <= 1'b0;
			idx_q <= 2'd0;
		end else if (start && !act_q) begin
			act_q <= 1'b1;
			idx_q <= 2'd0;
		end else if (push) begin
			if (idx_q == n_last)
				act_q <= 1'b0;
			idx_q <= idx_q + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (start && !act_q)
			cmd_q <= cmd;
	end

endmodule

`default_nettype wire

// ----- rtl/lge_queue.sv -----
// lge_queue: short first-in first-out queue of row operations
// decouples the command front from the grid back
// depends on lge_pkg
`default_nettype none

module lge_queue import lge_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push,
	input  wire uop_t push_uop,
	output logic      full,
	input  wire logic pop,
	output uop_t      head,
	output logic      empty
);

	uop_t                   slot_q [QUEUE_DEPTH];
	logic [QUEUE_PTR_W-1:0] wr_ptr_q;
	logic [QUEUE_PTR_W-1:0] rd_ptr_q;
	logic [QUEUE_PTR_W:0]   count_q;
	logic                   do_push;
	logic                   do_pop;

	assign full    = count_q == (QUEUE_PTR_W+1)'(QUEUE_DEPTH);
	assign empty   = count_q == '0;
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign head    = slot_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push)
				wr_ptr_q <= wr_ptr_q + QUEUE_PTR_W'(1);
			if (do_pop)
				rd_ptr_q <= rd_ptr_q + QUEUE_PTR_W'(1);
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + (QUEUE_PTR_W+1)'(1);
				2'b01:   count_q <= count_q - (QUEUE_PTR_W+1)'(1);
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (do_push)
			slot_q[wr_ptr_q] <= push_uop;
	end

endmodule

`default_nettype wire

// ----- rtl/lge_back.sv -----
// lge_back: grid memory and the sequencer that carries out row operations
// holds the cell rows, row valid bits, and the generation step datapath
// depends on lge_pkg
`default_nettype none

module lge_back import lge_pkg::*; #(
	parameter int GRID_ROWS = 64,
	parameter int GRID_COLS = 64
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic empty,
	input  wire uop_t head,
	output logic      pop,
	output logic      done,
	output rsp_t      result
);

	localparam int RW = (GRID_ROWS > 1) ? $clog2(GRID_ROWS) : 1;
	localparam int C  = GRID_COLS;

	typedef enum logic [4:0] {
		B_IDLE   = 5'b00001,
		B_WAIT   = 5'b00010,
		B_STEP_A = 5'b00100,
		B_STEP_B = 5'b01000,
		B_RUN    = 5'b10000
	} bstate_t;

	bstate_t         state_q;
	uop_t            op_q;
	logic [C-1:0]    grid_mem [GRID_ROWS];
	logic [GRID_ROWS-1:0] vld_q;
	logic [C-1:0]    rdata_q;
	logic            rvld_q;
	logic [C-1:0]    save0_q;
	logic [C-1:0]    prev_q;
	logic [C-1:0]    cur_q;
	logic [RW-1:0]   step_row_q;
	logic            done_q;
	rsp_t            rsp_q;

	logic            wr_en;
	logic [RW-1:0]   wr_addr;
	logic [C-1:0]    wr_data;
	logic            rd_en;
	logic [RW-1:0]   rd_addr;
	logic            clr;
	logic [C-1:0]    rd_row;
	logic [C-1:0]    nxt_row;
	logic [C-1:0]    life_row;
	logic            last_row;
	logic [RW:0]     ahead;

	assign rd_row   = rvld_q ? rdata_q : '0;
	assign last_row = step_row_q == RW'(GRID_ROWS - 1);
	assign nxt_row  = last_row ? save0_q : rd_row;
	assign ahead    = {1'b0, step_row_q} + (RW+1)'(2);
	assign pop      = (state_q == B_IDLE) && !empty;

	// b3/s23 rule on one row, neighbours wrap across the row ends
	always_comb begin
		logic [C-1:0] aw, ae, hw, he, bw, be;
		logic [3:0]   cnt;
		aw = {prev_q[C-2:0], prev_q[C-1]};
		ae = {prev_q[0], prev_q[C-1:1]};
		hw = {cur_q[C-2:0], cur_q[C-1]};
		he = {cur_q[0], cur_q[C-1:1]};
		bw = {nxt_row[C-2:0], nxt_row[C-1]};
		be = {nxt_row[0], nxt_row[C-1:1]};
		for (int c = 0; c < C; c++) begin
			cnt = 4'(aw[c]) + 4'(prev_q[c]) + 4'(ae[c]) + 4'(hw[c]) + 4'(he[c])
				+ 4'(bw[c]) + 4'(nxt_row[c]) + 4'(be[c]);
			life_row[c] = (cnt == 4'd3) || (cur_q[c] && cnt == 4'd2);
		end
	end

	always_comb begin
		wr_en   = 1'b0;
		wr_addr = '0;
		wr_data = '0;
		rd_en   = 1'b0;
		rd_addr = '0;
		clr     = 1'b0;
		case (state_q)
			B_IDLE: begin
				if (!empty) begin
					case (head.kind)
						UOP_WRITE: begin
							wr_en   = 1'b1;
							wr_addr = head.row[RW-1:0];
							wr_data = head.data[C-1:0];
						end
						UOP_CLEAR: clr = 1'b1;
						UOP_READ, UOP_SET: begin
							rd_en   = 1'b1;
							rd_addr = head.row[RW-1:0];
						end
						UOP_STEP: rd_en = 1'b1;
						default: ;
					endcase
				end
			end
			B_WAIT: begin
				if (op_q.kind == UOP_SET) begin
					wr_en   = 1'b1;
					wr_addr = op_q.row[RW-1:0];
					wr_data = rd_row | op_q.data[C-1:0];
				end
			end
			B_STEP_A: begin
				rd_en   = 1'b1;
				rd_addr = RW'(GRID_ROWS - 1);
			end
			B_STEP_B: begin
				rd_en   = 1'b1;
				rd_addr = RW'(1);
			end
			B_RUN: begin
				wr_en   = 1'b1;
				wr_addr = step_row_q;
				wr_data = life_row;
				rd_en   = ahead < (RW+1)'(GRID_ROWS);
				rd_addr = ahead[RW-1:0];
			end
			default: ;
		endcase
	end

	// grid rows, read data registered
	always_ff @(posedge clk) begin
		if (wr_en)
			grid_mem[wr_addr] <= wr_data;
		if (rd_en)
			rdata_q <= grid_mem[rd_addr];
	end

	// a row that is not valid reads as all dead
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q  <= '0;
			rvld_q <= 1'b0;
		end else begin
			if (clr)
				vld_q <= '0;
			else if (wr_en)
				vld_q[wr_addr] <= 1'b1;
			if (rd_en)
				rvld_q <= vld_q[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= B_IDLE;
			done_q     <= 1'b0;
			step_row_q <= '0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				B_IDLE: begin
					if (!empty) begin
						case (head.kind)
							UOP_READ, UOP_SET: state_q <= B_WAIT;
							UOP_STEP:          state_q <= B_STEP_A;
							default:           done_q  <= head.last;
						endcase
					end
				end
				B_WAIT: begin
					done_q  <= op_q.last;
					state_q <= B_IDLE;
				end
				B_STEP_A: state_q <= B_STEP_B;
				B_STEP_B: begin
					step_row_q <= '0;
					state_q    <= B_RUN;
				end
				B_RUN: begin
					if (last_row) begin
						step_row_q <= '0;
						done_q     <= 1'b1;
						state_q    <= B_IDLE;
					end else begin
						step_row_q <= step_row_q + RW'(1);
					end
				end
				default: state_q <= B_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			op_q                <= head;
			rsp_q.row_cells     <= '0;
			rsp_q.done_mode     <= head.mode;
		end
		if (state_q == B_WAIT && op_q.kind == UOP_READ)
			rsp_q.row_cells <= ROW_BITS'(rd_row);
		case (state_q)
			B_STEP_A: begin
				cur_q   <= rd_row;
				save0_q <= rd_row;
			end
			B_STEP_B: prev_q <= rd_row;
			B_RUN: begin
				prev_q <= cur_q;
				cur_q  <= nxt_row;
			end
			default: ;
		endcase
	end

	assign done   = done_q;
	assign result = rsp_q;

endmodule

`default_nettype wire

// ----- rtl/life_grid_engine.sv -----
// life_grid_engine: toroidal b3/s23 cell grid with row access, pattern placement and stepping
// top level joining the command front, the row-operation queue and the grid back
// depends on lge_pkg, lge_front, lge_queue, lge_back
`default_nettype none

// A command is taken when start is high and busy is low; every command gives
// exactly one response, shown for one cycle with done high, and the receiver
// cannot stall it. The front breaks a command into one row operation per row it
// touches (one for most commands, two for a block, three for a glider) and holds
// busy high until all are queued, stalling while the queue is full. The back does
// a row write, clear or ignored command from idle, a row read and each pattern row
// through a wait state, and a step through B_STEP_A, B_STEP_B and B_RUN, all set
// by the grid memory with one read and one write port and its registered read data.
// A queue of four row operations lets commands pile up behind a running step.
// The grid is dead after reset at once: per-row valid bits, no clearing pass.
module life_grid_engine import lge_pkg::*; #(
	parameter int GRID_ROWS = 64,
	parameter int GRID_COLS = 64
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic start,
	input  wire cmd_t cmd,
	output logic      busy,
	output logic      done,
	output rsp_t      result
);

	logic push;
	uop_t push_uop;
	logic full;
	logic pop;
	uop_t head;
	logic empty;

	lge_front #(
		.GRID_ROWS(GRID_ROWS),
		.GRID_COLS(GRID_COLS)
	) u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.cmd    (cmd),
		.busy   (busy),
		.push   (push),
		.uop    (push_uop),
		.full   (full)
	);

	lge_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_uop (push_uop),
		.full     (full),
		.pop      (pop),
		.head     (head),
		.empty    (empty)
	);

	lge_back #(
		.GRID_ROWS(GRID_ROWS),
		.GRID_COLS(GRID_COLS)
	) u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.empty  (empty),
		.head   (head),
		.pop    (pop),
		.done   (done),
		.result (result)
	);

endmodule

`default_nettype wire

// ----- tb/tb_top.sv -----
// tb_top: self-checking testbench for life_grid_engine, the toroidal b3/s23 cell grid
// drives commands through the start/busy handshake and checks every done response
// depends on lge_pkg and the life_grid_engine rtl
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;
	import lge_pkg::*;

	localparam int GRID_N        = 64;
	localparam int STIM_ITEMS    = 1650;
	localparam int SETTLE_CYCLES = 80;
	localparam int DRAIN_LIMIT   = 20000;
	localparam int N_DIRECTED    = 25;

	// modes the block must ignore
	localparam logic [2:0] MODE_SPARE_A = 3'd6;
	localparam logic [2:0] MODE_SPARE_B = 3'd7;

	localparam logic [63:0] ALL_LIVE  = '1;
	localparam logic [63:0] EDGE_BITS = 64'h8000_0000_0000_0001;

	typedef struct packed {
		cmd_t        c;
		logic        chk;
		logic [63:0] exp_cells;
	} directed_row_t;

	// directed table: chk rows carry a row_cells value known by inspection
	localparam directed_row_t DIRECTED [N_DIRECTED] = '{
		'{'{MODE_READ,    6'd0,  6'd0,  2'd0, 64'd0},     1'b1, 64'd0},
		'{'{MODE_READ,    6'd63, 6'd0,  2'd0, 64'd0},     1'b1, 64'd0},
		'{'{MODE_WRITE,   6'd0,  6'd0,  2'd0, ALL_LIVE},  1'b1, 64'd0},
		'{'{MODE_READ,    6'd0,  6'd0,  2'd0, 64'd0},     1'b1, ALL_LIVE},
		'{'{MODE_WRITE,   6'd63, 6'd0,  2'd0, EDGE_BITS}, 1'b1, 64'd0},
		'{'{MODE_READ,    6'd63, 6'd0,  2'd0, 64'd0},     1'b1, EDGE_BITS},
		'{'{MODE_STEP,    6'd0,  6'd0,  2'd0, 64'd0},     1'b1, 64'd0},
		'{'{MODE_READ,    6'd0,  6'd0,  2'd0, 64'd0},     1'b0, 64'd0},
		'{'{MODE_READ,    6'd63, 6'd0,  2'd0, 64'd0},     1'b0, 64'd0},
		'{'{MODE_READ,    6'd1,  6'd0,  2'd0, 64'd0},     1'b0, 64'd0},
		'{'{MODE_CLEAR,   6'd0,  6'd0,  2'd0, 64'd0},     1'b1, 64'd0},
		'{'{MODE_READ,    6'd0,  6'd0,  2'd0, 64'd0},     1'b1, 64'd0},
		'{'{MODE_BLOCK,   6'd63, 6'd63, 2'd0, 64'd0},     1'b1, 64'd0},
		'{'{MODE_READ,    6'd63, 6'd0,  2'd0, 64'd0},     1'b1, EDGE_BITS},
		'{'{MODE_READ,    6'd0,  6'd0,  2'd0, 64'd0},     1'b1, EDGE_BITS},
		'{'{MODE_GLIDER,  6'd0,  6'd0,  2'd0, 64'd0},     1'b0, 64'd0},
		'{'{MODE_GLIDER,  6'd32, 6'd63, 2'd1, 64'd0},     1'b0, 64'd0},
		'{'{MODE_GLIDER,  6'd63, 6'd32, 2'd2, 64'd0},     1'b0, 64'd0},
		'{'{MODE_GLIDER,  6'd40, 6'd10, 2'd3, 64'd0},     1'b0, 64'd0},
		'{'{MODE_READ,    6'd63, 6'd0,  2'd0, 64'd0},     1'b0, 64'd0},
		'{'{MODE_READ,    6'd0,  6'd0,  2'd0, 64'd0},     1'b0, 64'd0},
		'{'{MODE_STEP,    6'd0,  6'd0,  2'd0, 64'd0},     1'b1, 64'd0},
		'{'{MODE_READ,    6'd1,  6'd0,  2'd0, 64'd0},     1'b0, 64'd0},
		'{'{MODE_SPARE_A, 6'd63, 6'd63, 2'd3, ALL_LIVE},  1'b1, 64'd0},
		'{'{MODE_SPARE_B, 6'd0,  6'd0,  2'd0, 64'd0},     1'b1, 64'd0}
	};

	logic clk    = 1'b0;
	logic arst_n = 1'b0;
	logic start  = 1'b0;
	cmd_t cmd    = '0;
	logic busy;
	logic done;
	rsp_t result;

	logic [63:0] life_grid [GRID_N];
	rsp_t        expected_rsp_q [$];
	int          err_count     = 0;
	int          items_sent    = 0;
	int          rsp_checked   = 0;
	int          mode_seen [8] = '{default: 0};
	bit          idle_on       = 1'b1;

	life_grid_engine u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.cmd    (cmd),
		.busy   (busy),
		.done   (done),
		.result (result)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	initial begin
		#8_000_000;
		$display("timeout with %0d responses outstanding", expected_rsp_q.size());
		$display("Simulation FAILED");
		$finish;
	end

	task automatic report_mismatch(input string what, input logic [63:0] got,
			input logic [63:0] want);
		$display("%0t ns mismatch: %s got %h want %h", $time, what, got, want);
		err_count++;
	endtask

	// b3/s23 on one row, columns wrap through 6-bit arithmetic
	function automatic logic [63:0] life_row(input logic [63:0] above, input logic [63:0] here,
			input logic [63:0] below);
		logic [63:0] nxt;
		logic [5:0]  w;
		logic [5:0]  e;
		int          cnt;
		nxt = '0;
		for (int c = 0; c < GRID_N; c++) begin
			w = 6'(c - 1);
			e = 6'(c + 1);
			cnt = 0;
			cnt += above[w] + above[c] + above[e];
			cnt += here[w] + here[e];
			cnt += below[w] + below[c] + below[e];
			nxt[c] = (cnt == 3) || (here[c] && cnt == 2);
		end
		return nxt;
	endfunction

	// applies one command to the grid copy and gives the response it should produce
	task automatic life_apply(input cmd_t c, output rsp_t r);
		logic [63:0] old [GRID_N];
		logic [5:0]  u;
		logic [5:0]  d;
		logic [5:0]  l;
		logic [5:0]  g;
		logic [5:0]  head;
		logic [5:0]  tail;
		logic [5:0]  side;
		r.row_cells = '0;
		r.done_mode = c.mode;
		u = c.row - 6'd1;
		d = c.row + 6'd1;
		l = c.col - 6'd1;
		g = c.col + 6'd1;
		case (c.mode)
			MODE_WRITE: life_grid[c.row] = c.row_data;
			MODE_READ: r.row_cells = life_grid[c.row];
			MODE_CLEAR: begin
				foreach (life_grid[i]) life_grid[i] = '0;
			end
			MODE_BLOCK: begin
				life_grid[c.row][c.col] = 1'b1;
				life_grid[c.row][g]     = 1'b1;
				life_grid[d][c.col]     = 1'b1;
				life_grid[d][g]         = 1'b1;
			end
			MODE_GLIDER: begin
				head = c.direction[1] ? d : u;
				tail = c.direction[1] ? u : d;
				side = c.direction[0] ? g : l;
				life_grid[head][l]     = 1'b1;
				life_grid[head][c.col] = 1'b1;
				life_grid[head][g]     = 1'b1;
				life_grid[c.row][side] = 1'b1;
				life_grid[tail][c.col] = 1'b1;
			end
			MODE_STEP: begin
				old = life_grid;
				for (int i = 0; i < GRID_N; i++)
					life_grid[i] = life_row(old[6'(i - 1)], old[i], old[6'(i + 1)]);
			end
			default: ;
		endcase
	endtask

	// one transaction: optional idle cycles, then hold start until busy is low at an edge
	task automatic send_cmd(input cmd_t c, input bit typed, input logic [63:0] typed_cells);
		rsp_t        want;
		logic [95:0] junk;
		@(negedge clk);
		while (idle_on && $urandom_range(99) < 21) begin
			junk  = {$urandom, $urandom, $urandom};
			start = 1'b0;
			cmd   = junk[80:0];
			@(negedge clk);
		end
		start = 1'b1;
		cmd   = c;
		do @(posedge clk); while (busy !== 1'b0);
		life_apply(c, want);
		if (typed)
			want.row_cells = typed_cells;
		expected_rsp_q.push_back(want);
		items_sent++;
		mode_seen[c.mode]++;
	endtask

	// sender holds off until every pending response is back, or until the drain guard runs out
	task automatic drain_pending();
		int guard;
		guard = 0;
		@(negedge clk);
		start = 1'b0;
		while (expected_rsp_q.size() != 0 && guard < DRAIN_LIMIT) begin
			@(posedge clk);
			guard++;
		end
	endtask

	function automatic cmd_t rand_cmd(input logic [2:0] mode);
		cmd_t c;
		c.mode      = mode;
		c.row       = 6'($urandom_range(63));
		c.col       = 6'($urandom_range(63));
		c.direction = 2'($urandom_range(3));
		case ($urandom_range(9))
			0: c.row_data = '0;
			1: c.row_data = '1;
			2, 3, 4: c.row_data = {$urandom, $urandom} & {$urandom, $urandom};
			5: c.row_data = {$urandom, $urandom} | {$urandom, $urandom};
			default: c.row_data = {$urandom, $urandom};
		endcase
		return c;
	endfunction

	// seed a pattern, then run a few generations with row reads in between
	task automatic run_episode();
		int n_seed;
		int n_gen;
		int n_rd;
		int pick;
		if ($urandom_range(3) != 0)
			send_cmd(rand_cmd(MODE_CLEAR), 1'b0, '0);
		n_seed = $urandom_range(12, 2);
		repeat (n_seed) begin
			pick = $urandom_range(9);
			if (pick < 5)
				send_cmd(rand_cmd(MODE_WRITE), 1'b0, '0);
			else if (pick < 7)
				send_cmd(rand_cmd(MODE_BLOCK), 1'b0, '0);
			else if (pick < 9)
				send_cmd(rand_cmd(MODE_GLIDER), 1'b0, '0);
			else
				send_cmd(rand_cmd(MODE_READ), 1'b0, '0);
		end
		n_gen = $urandom_range(8, 1);
		repeat (n_gen) begin
			send_cmd(rand_cmd(MODE_STEP), 1'b0, '0);
			n_rd = $urandom_range(4);
			repeat (n_rd) send_cmd(rand_cmd(MODE_READ), 1'b0, '0);
			// noise: any mode, spare modes included
			if ($urandom_range(19) == 0)
				send_cmd(rand_cmd(3'($urandom_range(7))), 1'b0, '0);
		end
	endtask

	always @(posedge clk) begin
		rsp_t want;
		if (arst_n && done === 1'b1) begin
			if (expected_rsp_q.size() == 0) begin
				report_mismatch("response with no transaction pending", result.row_cells, '0);
			end else begin
				want = expected_rsp_q.pop_front();
				rsp_checked++;
				if (result.done_mode !== want.done_mode)
					report_mismatch("done_mode", 64'(result.done_mode), 64'(want.done_mode));
				if (result.row_cells !== want.row_cells)
					report_mismatch($sformatf("row_cells (mode %0d)", want.done_mode),
						result.row_cells, want.row_cells);
			end
		end
	end

	initial begin
		foreach (life_grid[i]) life_grid[i] = '0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		foreach (DIRECTED[i])
			send_cmd(DIRECTED[i].c, DIRECTED[i].chk, DIRECTED[i].exp_cells);
		drain_pending();

		while (items_sent < N_DIRECTED + STIM_ITEMS) begin
			// one long stretch where the sender never idles
			idle_on = !(items_sent >= 700 && items_sent < 1000);
			run_episode();
			if ($urandom_range(7) == 0)
				drain_pending();
		end

		drain_pending();
		repeat (SETTLE_CYCLES) @(posedge clk);
		while (expected_rsp_q.size() != 0)
			report_mismatch("response never arrived", '0, expected_rsp_q.pop_front().row_cells);

		$display("covered %0d transactions: %0d writes, %0d reads, %0d clears, %0d blocks,",
			items_sent, mode_seen[MODE_WRITE], mode_seen[MODE_READ], mode_seen[MODE_CLEAR],
			mode_seen[MODE_BLOCK]);
		$display("  %0d gliders, %0d generation steps, %0d spare modes; %0d responses checked",
			mode_seen[MODE_GLIDER], mode_seen[MODE_STEP],
			mode_seen[MODE_SPARE_A] + mode_seen[MODE_SPARE_B], rsp_checked);
		if (err_count == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("%0d mismatches", err_count);
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule
